[hdl/avcl2a_pkg.sv]
// Shared types and constants for the length-prefix to start-code converter.
// No dependencies; imported by all hdl modules.
package avcl2a_pkg;

	// APB register map
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_LENGTH_SIZE  = 1'b0;
	localparam logic REG_OUT_CAPACITY = 1'b1;

	// Unit status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TOOBIG  = 2'd2;

	// NAL header fields
	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [4:0] NAL_IDR = 5'd5;
	localparam logic [4:0] NAL_SPS = 5'd7;
	localparam logic [4:0] NAL_PPS = 5'd8;

	localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_PAY  = 4'b0010,
		PH_STOP = 4'b0100,
		PH_DROP = 4'b1000
	} phase_t;

	// All results caused by one input word: start code, one mid result
	// (payload byte or flag-only), then the closing result.
	typedef struct packed {
		logic        has_sc;
		logic        has_mid;
		logic        mid_valid;
		logic [7:0]  mid_byte;
		logic        mid_idr;
		logic        has_done;
		logic [1:0]  status;
		logic [31:0] total;
	} bundle_t;

	function automatic logic [2:0] bundle_count(input bundle_t b);
		bundle_count = (b.has_sc ? 3'd4 : 3'd0) + {2'b00, b.has_mid} + {2'b00, b.has_done};
	endfunction

endpackage

[hdl/avcl2a_ifs.sv]
// Valid/ready channel interfaces for the converter's input and result words.
// No dependencies.
interface avcl2a_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, in_byte, last_byte, input ready);
	modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface avcl2a_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        idr_without_param_sets;
	logic        unit_done;
	logic [1:0]  unit_status;
	logic [31:0] total_bytes;

	modport source (output valid, out_byte, byte_valid, run_last, idr_without_param_sets,
		unit_done, unit_status, total_bytes, input ready);
	modport sink   (input valid, out_byte, byte_valid, run_last, idr_without_param_sets,
		unit_done, unit_status, total_bytes, output ready);
endinterface

[hdl/avcl2a_cfg.sv]
// APB register block: length_size and out_capacity.
// Depends on avcl2a_pkg.
module avcl2a_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [avcl2a_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output logic [2:0]                    length_size,
	output logic [31:0]                   out_capacity
);
	import avcl2a_pkg::*;

	logic [2:0]  length_size_q;
	logic [31:0] out_capacity_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_size_q  <= 3'd4;
			out_capacity_q <= 32'hffff_ffff;
		end else if (wr_en) begin
			if (paddr[2] == REG_LENGTH_SIZE) length_size_q <= pwdata[2:0];
			else out_capacity_q <= pwdata;
		end
	end

	always_comb begin
		if (paddr[2] == REG_OUT_CAPACITY) prdata = out_capacity_q;
		else prdata = {29'd0, length_size_q};
	end

	assign length_size  = length_size_q;
	assign out_capacity = out_capacity_q;
endmodule

[hdl/avcl2a_parser.sv]
// Per-unit parse state and next-state logic; builds the result bundle of a word.
// Depends on avcl2a_pkg.
module avcl2a_parser #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          in_byte,
	input  logic                last_byte,
	input  logic [2:0]          length_size,
	input  logic [31:0]         out_capacity,
	output avcl2a_pkg::bundle_t bundle
);
	import avcl2a_pkg::*;

	localparam logic [33:0] CMAX = (34'd1 << COUNT_BITS) - 34'd1;

	phase_t                phase_q, phase_n;
	logic [31:0]           len_q, len_n;
	logic [2:0]            seen_q, seen_n;
	logic [31:0]           left_q, left_n;
	logic                  hdr_q, hdr_n;
	logic                  ps_q, ps_n;
	logic [COUNT_BITS-1:0] cnt_q, cnt_n;
	logic [1:0]            st_q, st_n;

	logic [2:0]  lsz;
	logic [31:0] acc_new;
	logic [2:0]  seen_new;
	logic [33:0] need;
	logic [33:0] limit;
	logic [4:0]  nal_type;
	logic        idr;
	logic        trunc;

	always_comb begin
		if (length_size == 3'd0) lsz = 3'd1;
		else if (length_size > 3'd4) lsz = 3'd4;
		else lsz = length_size;
	end

	assign acc_new  = {len_q[23:0], in_byte};
	assign seen_new = seen_q + 3'd1;
	assign need     = 34'(cnt_q) + 34'd4 + {2'b00, acc_new};
	assign limit    = ({2'b00, out_capacity} > CMAX) ? CMAX : {2'b00, out_capacity};
	assign nal_type = in_byte[4:0] & NAL_TYPE_MASK;

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		seen_n  = seen_q;
		left_n  = left_q;
		hdr_n   = hdr_q;
		ps_n    = ps_q;
		cnt_n   = cnt_q;
		st_n    = st_q;
		idr     = 1'b0;
		trunc   = 1'b0;
		bundle  = '0;

		case (phase_q)
			PH_LEN: begin
				if (seen_new >= lsz) begin
					if (acc_new == 32'd0) begin
						st_n    = ST_INVALID;
						phase_n = PH_STOP;
					end else begin
						if (need > limit) begin
							if (st_q == ST_OK) st_n = ST_TOOBIG;
							phase_n = PH_DROP;
						end else begin
							bundle.has_sc = 1'b1;
							cnt_n   = cnt_q + COUNT_BITS'(4);
							phase_n = PH_PAY;
						end
						left_n = acc_new;
						hdr_n  = 1'b1;
					end
					len_n  = '0;
					seen_n = '0;
				end else begin
					len_n  = acc_new;
					seen_n = seen_new;
				end
			end
			PH_PAY, PH_DROP: begin
				if (hdr_q) begin
					if (nal_type == NAL_SPS || nal_type == NAL_PPS) begin
						ps_n = 1'b1;
					end else if (nal_type == NAL_IDR && !ps_q) begin
						idr  = 1'b1;
						ps_n = 1'b1;
					end
					hdr_n = 1'b0;
				end
				if (phase_q == PH_PAY) begin
					bundle.has_mid   = 1'b1;
					bundle.mid_valid = 1'b1;
					bundle.mid_byte  = in_byte;
					bundle.mid_idr   = idr;
					cnt_n = cnt_q + COUNT_BITS'(1);
				end else if (idr) begin
					bundle.has_mid = 1'b1;
					bundle.mid_idr = 1'b1;
				end
				left_n = left_q - 32'd1;
				if (left_n == 32'd0) phase_n = PH_LEN;
			end
			default: begin
			end
		endcase

		if (last_byte) begin
			trunc = (phase_n == PH_LEN && seen_n != 3'd0) ||
				((phase_n == PH_PAY || phase_n == PH_DROP) && left_n != 32'd0);
			if (trunc) st_n = ST_INVALID;
			bundle.has_done = 1'b1;
			bundle.status   = st_n;
			bundle.total    = (st_n == ST_OK) ? 32'(cnt_n) : 32'd0;
			// unit closes: clear everything
			phase_n = PH_LEN;
			len_n   = '0;
			seen_n  = '0;
			left_n  = '0;
			hdr_n   = 1'b0;
			ps_n    = 1'b0;
			cnt_n   = '0;
			st_n    = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			len_q   <= '0;
			seen_q  <= '0;
			left_q  <= '0;
			hdr_q   <= 1'b0;
			ps_q    <= 1'b0;
			cnt_q   <= '0;
			st_q    <= ST_OK;
		end else if (accept) begin
			phase_q <= phase_n;
			len_q   <= len_n;
			seen_q  <= seen_n;
			left_q  <= left_n;
			hdr_q   <= hdr_n;
			ps_q    <= ps_n;
			cnt_q   <= cnt_n;
			st_q    <= st_n;
		end
	end
endmodule

[hdl/avcl2a_emitter.sv]
// Result register: holds one word's bundle and hands its results out one a cycle while dout.ready is high.
// Depends on avcl2a_pkg and avcl2a_out_if.
module avcl2a_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  avcl2a_pkg::bundle_t bundle,
	output logic                in_ready,
	avcl2a_out_if.source        dout
);
	import avcl2a_pkg::*;

	bundle_t    bnd_q;
	logic       vld_q;
	logic [2:0] idx_q;
	logic [2:0] nres;
	logic [2:0] sc_n;
	logic       last_res;
	logic       take;

	assign nres     = bundle_count(bnd_q);
	assign sc_n     = bnd_q.has_sc ? 3'd4 : 3'd0;
	assign last_res = (idx_q == nres - 3'd1);
	assign take     = vld_q & dout.ready;
	assign in_ready = !vld_q || (dout.ready && last_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (accept && bundle_count(bundle) != 3'd0) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (take && last_res) begin
			vld_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) bnd_q <= bundle;
	end

	always_comb begin
		dout.valid                  = vld_q;
		dout.run_last               = last_res;
		dout.out_byte               = 8'd0;
		dout.byte_valid             = 1'b0;
		dout.idr_without_param_sets = 1'b0;
		dout.unit_done              = 1'b0;
		dout.unit_status            = ST_OK;
		dout.total_bytes            = 32'd0;
		if (bnd_q.has_sc && idx_q < 3'd4) begin
			dout.out_byte   = START_CODE[idx_q[1:0]];
			dout.byte_valid = 1'b1;
		end else if (bnd_q.has_mid && idx_q == sc_n) begin
			dout.out_byte               = bnd_q.mid_byte;
			dout.byte_valid             = bnd_q.mid_valid;
			dout.idr_without_param_sets = bnd_q.mid_idr;
		end else begin
			dout.unit_done   = 1'b1;
			dout.unit_status = bnd_q.status;
			dout.total_bytes = bnd_q.total;
		end
	end

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.unit_done |-> dout.run_last)
		else $error("closing result not last of its word");
	a_flag_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.byte_valid |-> dout.out_byte == 8'd0)
		else $error("status-only result carries a byte");
	a_bad_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.unit_done && dout.unit_status != ST_OK |-> dout.total_bytes == 32'd0)
		else $error("failed unit reports a byte total");
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> dout.valid && (!dout.ready || !dout.run_last))
		else $error("input held off with no result pending");
endmodule

[hdl/avc_length_prefix_to_annexb.sv]
// Top level of the length-prefixed H.264 to start-code byte stream converter.
// Depends on avcl2a_pkg, avcl2a_ifs, avcl2a_cfg, avcl2a_parser, avcl2a_emitter.
//
// Usage:
//   din  carries one byte of an access unit per word, last_byte on the final one.
//   dout carries one result per word: start code or NAL byte (byte_valid = 1),
//        a status-only IDR flag (byte_valid = 0), or the closing unit_done word
//        with unit_status and total_bytes. run_last marks the final result
//        caused by each input word.
//   APB  programs length_size (0x0) and out_capacity (0x4); write only while idle.
// The result register loads a word's bundle as the word is accepted; its first result is offered in the next cycle.
// Results: a payload byte makes one result; the word that completes a length
//   makes the four start-code bytes, and the last word of a unit one more for
//   the closing result. The single result register hands out one result per
//   cycle while dout.ready is high and takes the next word in the cycle its
//   last result leaves. Length bytes, and dropped payload bytes other than
//   an IDR flag, make no result and pass at one per cycle with no result pending.
// Reset: arst_n clears the parse state to "reading length" and empties the
//   result register; registers return to length_size 4, out_capacity all ones.
// Stall: while dout.ready is low the pending result holds and din.ready stays
//   low; din.ready is high only with no result pending or as the last result
//   of a word leaves.
module avc_length_prefix_to_annexb #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	avcl2a_in_if.sink                     din,
	avcl2a_out_if.source                  dout,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [avcl2a_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import avcl2a_pkg::*;

	logic        accept;
	logic        in_ready;
	logic [2:0]  length_size;
	logic [31:0] out_capacity;
	bundle_t     bundle;

	// a word is taken when the result register can load its bundle
	assign din.ready = in_ready;
	assign accept    = din.valid & in_ready;

	avcl2a_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.length_size  (length_size),
		.out_capacity (out_capacity)
	);

	// parse state lives here; bundle is pure logic off the input word
	avcl2a_parser #(
		.COUNT_BITS (COUNT_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (din.in_byte),
		.last_byte    (din.last_byte),
		.length_size  (length_size),
		.out_capacity (out_capacity),
		.bundle       (bundle)
	);

	// result register and serializer
	avcl2a_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.bundle   (bundle),
		.in_ready (in_ready),
		.dout     (dout)
	);
endmodule
